// ===== src/tournament_branch_predictor_top_assert.svh =====
// Assertion macros for the tournament branch predictor.
// Clocked on clk, disabled while rst_n is low.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TBP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TBP_ASSERT_IMP(label, ante, cons)
`define TBP_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/tbp_pkg.sv =====
package tbp_pkg;

  localparam int MAX_GLOBAL_BITS = 12;
  localparam int MAX_LOCAL_BITS  = 12;
  localparam int MAX_PC_BITS     = 12;

  localparam int GLOBAL_DEPTH = 1 << MAX_GLOBAL_BITS;
  localparam int LOCAL_DEPTH  = 1 << MAX_LOCAL_BITS;
  localparam int PC_DEPTH     = 1 << MAX_PC_BITS;

  localparam int CLR_W = (MAX_GLOBAL_BITS > MAX_LOCAL_BITS) ?
                         ((MAX_GLOBAL_BITS > MAX_PC_BITS) ? MAX_GLOBAL_BITS : MAX_PC_BITS) :
                         ((MAX_LOCAL_BITS > MAX_PC_BITS) ? MAX_LOCAL_BITS : MAX_PC_BITS);

  localparam int MASK_W   = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int CFG_BITS = 4;

  localparam logic [1:0] CFG_IDX_GHB = 2'd0;
  localparam logic [1:0] CFG_IDX_LHB = 2'd1;
  localparam logic [1:0] CFG_IDX_PCB = 2'd2;

  localparam logic [CFG_BITS-1:0] GHB_RST = 4'd9;
  localparam logic [CFG_BITS-1:0] LHB_RST = 4'd10;
  localparam logic [CFG_BITS-1:0] PCB_RST = 4'd10;

  localparam logic [1:0] CTR_RST     = 2'd1;
  localparam logic [1:0] CHOOSER_RST = 2'd2;

  typedef struct packed {
    logic [CFG_BITS-1:0] gbits;
    logic [CFG_BITS-1:0] lbits;
    logic [CFG_BITS-1:0] pbits;
  } tbp_cfg_t;

  typedef struct packed {
    logic [1:0] chooser;
    logic [1:0] gctr;
  } tbp_gent_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LREAD,
    S_EXEC
  } tbp_state_t;

  function automatic logic [MASK_W-1:0] width_mask(input logic [CFG_BITS-1:0] bits,
                                                   input logic [4:0] max_bits);
    logic [4:0] b;
    b = {1'b0, bits};
    if (b == 5'd0) b = 5'd1;
    if (b > max_bits) b = max_bits;
    width_mask = ~({MASK_W{1'b1}} << b);
  endfunction

  function automatic logic [1:0] counter_step(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    counter_step = r;
  endfunction

endpackage

// ===== src/tbp_in_if.sv =====
interface tbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] pc;
  logic        outcome;

  modport source(output valid, action, pc, outcome, input ready);
  modport sink(input valid, action, pc, outcome, output ready);
endinterface

// ===== src/tbp_out_if.sv =====
interface tbp_out_if;
  logic valid;
  logic ready;
  logic prediction;

  modport source(output valid, prediction, input ready);
  modport sink(input valid, prediction, output ready);
endinterface

// ===== src/tbp_ram.sv =====
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tbp_cfg.sv =====
module tbp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbp_pkg::CFG_AW-1:0]   paddr,
  input  logic [tbp_pkg::CFG_DW-1:0]   pwdata,
  output logic [tbp_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output tbp_pkg::tbp_cfg_t            cfg
);
  import tbp_pkg::*;

  tbp_cfg_t   cfg_r;
  tbp_cfg_t   cfg_nxt;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        CFG_IDX_GHB: cfg_nxt.gbits = pwdata[CFG_BITS-1:0];
        CFG_IDX_LHB: cfg_nxt.lbits = pwdata[CFG_BITS-1:0];
        CFG_IDX_PCB: cfg_nxt.pbits = pwdata[CFG_BITS-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gbits <= GHB_RST;
      cfg_r.lbits <= LHB_RST;
      cfg_r.pbits <= PCB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      CFG_IDX_GHB: prdata = {{(CFG_DW-CFG_BITS){1'b0}}, cfg_r.gbits};
      CFG_IDX_LHB: prdata = {{(CFG_DW-CFG_BITS){1'b0}}, cfg_r.lbits};
      CFG_IDX_PCB: prdata = {{(CFG_DW-CFG_BITS){1'b0}}, cfg_r.pbits};
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tournament_branch_predictor_top.sv =====
// Tournament branch predictor (local and global sides with a chooser). After reset the
// block sweeps every entry of its tables and takes no item meanwhile; register writes
// are taken at any time. An item passes through the states in order: in S_IDLE the accept
// reads the local history table and the global/chooser table, S_LREAD reads the local
// counter table at the stored history, and S_EXEC forms the prediction or writes back
// all three tables and the global history. The next item is accepted only once S_EXEC
// has returned to S_IDLE, so items never overlap; a prediction holds in S_EXEC while an
// earlier result waits on the output.
module tournament_branch_predictor_top (
  input  logic                       clk,
  input  logic                       rst_n,
  tbp_in_if.sink                     in_ch,
  tbp_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tbp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tbp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tbp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import tbp_pkg::*;

  localparam int GW = MAX_GLOBAL_BITS;
  localparam int LW = MAX_LOCAL_BITS;
  localparam int PW = MAX_PC_BITS;

  tbp_cfg_t cfg;

  tbp_state_t       state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [GW-1:0]    gh_r, gh_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_pred_r, out_pred_nxt;
  logic             action_r, action_nxt;
  logic             outc_r, outc_nxt;
  logic [PW-1:0]    pidx_r, pidx_nxt;
  logic [GW-1:0]    gidx_r, gidx_nxt;
  logic [LW-1:0]    lidx_r, lidx_nxt;

  logic [MASK_W-1:0] gmask, lmask, pmask;

  logic          lht_we, lht_re;
  logic [PW-1:0] lht_waddr, lht_raddr;
  logic [LW-1:0] lht_wdata, lht_rdata;

  logic          lctr_we, lctr_re;
  logic [LW-1:0] lctr_waddr, lctr_raddr;
  logic [1:0]    lctr_wdata, lctr_rdata;

  logic          gtab_we, gtab_re;
  logic [GW-1:0] gtab_waddr, gtab_raddr;
  tbp_gent_t     gtab_wdata, gtab_rdata;

  logic          in_ready;
  logic          accept;
  logic          ldir, gdir;
  logic [1:0]    chooser_new;

  tbp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tbp_ram #(.WIDTH(LW), .DEPTH(PC_DEPTH)) u_lht (
    .clk   (clk),
    .we    (lht_we),
    .waddr (lht_waddr),
    .wdata (lht_wdata),
    .re    (lht_re),
    .raddr (lht_raddr),
    .rdata (lht_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(LOCAL_DEPTH)) u_lctr (
    .clk   (clk),
    .we    (lctr_we),
    .waddr (lctr_waddr),
    .wdata (lctr_wdata),
    .re    (lctr_re),
    .raddr (lctr_raddr),
    .rdata (lctr_rdata)
  );

  tbp_ram #(.WIDTH($bits(tbp_gent_t)), .DEPTH(GLOBAL_DEPTH)) u_gtab (
    .clk   (clk),
    .we    (gtab_we),
    .waddr (gtab_waddr),
    .wdata (gtab_wdata),
    .re    (gtab_re),
    .raddr (gtab_raddr),
    .rdata (gtab_rdata)
  );

  assign gmask = width_mask(cfg.gbits, 5'(MAX_GLOBAL_BITS));
  assign lmask = width_mask(cfg.lbits, 5'(MAX_LOCAL_BITS));
  assign pmask = width_mask(cfg.pbits, 5'(MAX_PC_BITS));

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ready;

  assign ldir = lctr_rdata[1];
  assign gdir = gtab_rdata.gctr[1];

  always_comb begin
    chooser_new = gtab_rdata.chooser;
    if (gdir == outc_r && ldir != outc_r) begin
      chooser_new = counter_step(gtab_rdata.chooser, 1'b1);
    end else if (ldir == outc_r && gdir != outc_r) begin
      chooser_new = counter_step(gtab_rdata.chooser, 1'b0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    gh_nxt        = gh_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pred_nxt  = out_pred_r;
    action_nxt    = action_r;
    outc_nxt      = outc_r;
    pidx_nxt      = pidx_r;
    gidx_nxt      = gidx_r;
    lidx_nxt      = lidx_r;

    lht_we     = 1'b0;
    lht_re     = 1'b0;
    lht_waddr  = pidx_r;
    lht_raddr  = in_ch.pc[PW-1:0] & pmask[PW-1:0];
    lht_wdata  = ((lidx_r << 1) | LW'(outc_r)) & lmask[LW-1:0];
    lctr_we    = 1'b0;
    lctr_re    = 1'b0;
    lctr_waddr = lidx_r;
    lctr_raddr = lht_rdata & lmask[LW-1:0];
    lctr_wdata = counter_step(lctr_rdata, outc_r);
    gtab_we    = 1'b0;
    gtab_re    = 1'b0;
    gtab_waddr = gidx_r;
    gtab_raddr = gh_r & gmask[GW-1:0];
    gtab_wdata.chooser = chooser_new;
    gtab_wdata.gctr    = counter_step(gtab_rdata.gctr, outc_r);

    case (state_r)
      S_CLEAR: begin
        lht_we             = 1'b1;
        lht_waddr          = clr_cnt_r[PW-1:0];
        lht_wdata          = '0;
        lctr_we            = 1'b1;
        lctr_waddr         = clr_cnt_r[LW-1:0];
        lctr_wdata         = CTR_RST;
        gtab_we            = 1'b1;
        gtab_waddr         = clr_cnt_r[GW-1:0];
        gtab_wdata.chooser = CHOOSER_RST;
        gtab_wdata.gctr    = CTR_RST;
        clr_cnt_nxt        = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          lht_re     = 1'b1;
          gtab_re    = 1'b1;
          action_nxt = in_ch.action;
          outc_nxt   = in_ch.outcome;
          pidx_nxt   = lht_raddr;
          gidx_nxt   = gtab_raddr;
          state_nxt  = S_LREAD;
        end
      end
      S_LREAD: begin
        lctr_re   = 1'b1;
        lidx_nxt  = lctr_raddr;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!action_r) begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            out_pred_nxt  = gtab_rdata.chooser[1] ? gdir : ldir;
            state_nxt     = S_IDLE;
          end
        end else begin
          lht_we    = 1'b1;
          lctr_we   = 1'b1;
          gtab_we   = 1'b1;
          gh_nxt    = ((gidx_r << 1) | GW'(outc_r)) & gmask[GW-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      gh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      gh_r        <= gh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pred_r <= out_pred_nxt;
    action_r   <= action_nxt;
    outc_r     <= outc_nxt;
    pidx_r     <= pidx_nxt;
    gidx_r     <= gidx_nxt;
    lidx_r     <= lidx_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.prediction = out_pred_r;

`include "tournament_branch_predictor_top_assert.svh"

  `TBP_ASSERT_NXT(a_accept_reads_local, accept, state_r == S_LREAD)
  `TBP_ASSERT_IMP(a_train_write_exec, state_r != S_CLEAR && (lht_we || gtab_we),
                  state_r == S_EXEC && action_r)
  `TBP_ASSERT_NXT(a_predict_delivers, state_r == S_EXEC && !action_r && out_ch.ready,
                  out_valid_r)
  `TBP_ASSERT_IMP(a_no_accept_clear, state_r == S_CLEAR, !in_ch.ready)

endmodule
